// ===== design/srcd_pkg.sv =====
// Package for the serial robot command decoder.
// Holds the command byte codes, action and pending mode codes, and the result
// item type. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package srcd_pkg;

  localparam logic [7:0] CMD_FWD       = 8'h38;
  localparam logic [7:0] CMD_BACK      = 8'h32;
  localparam logic [7:0] CMD_RIGHT     = 8'h34;
  localparam logic [7:0] CMD_LEFT      = 8'h36;
  localparam logic [7:0] CMD_STOP      = 8'h35;
  localparam logic [7:0] CMD_BUZZ_ON   = 8'h37;
  localparam logic [7:0] CMD_BUZZ_OFF  = 8'h39;
  localparam logic [7:0] CMD_FULL_SPD  = 8'h53;
  localparam logic [7:0] CMD_SENSOR    = 8'h54;
  localparam logic [7:0] CMD_ID        = 8'h6B;
  localparam logic [7:0] CMD_VEL       = 8'h52;
  localparam logic [7:0] CMD_FWD_DIST  = 8'h55;
  localparam logic [7:0] CMD_BACK_DIST = 8'h56;
  localparam logic [7:0] CMD_ROT_R     = 8'h57;
  localparam logic [7:0] CMD_ROT_L     = 8'h58;
  localparam logic [7:0] CMD_SERVO1    = 8'h80;
  localparam logic [7:0] CMD_SERVO2    = 8'h81;
  localparam logic [7:0] CMD_SERVO3    = 8'h82;
  localparam logic [7:0] CMD_LCD       = 8'h83;
  localparam logic [7:0] CMD_BAR       = 8'h84;

  localparam logic [3:0] DIR_FWD   = 4'd6;
  localparam logic [3:0] DIR_BACK  = 4'd9;
  localparam logic [3:0] DIR_RIGHT = 4'd10;
  localparam logic [3:0] DIR_LEFT  = 4'd5;
  localparam logic [3:0] DIR_STOP  = 4'd0;

  localparam logic [7:0] FULL_SPEED = 8'd255;
  localparam logic [7:0] DEVICE_ID_RESET = 8'd5;

  typedef enum logic [3:0] {
    ACT_MOTION    = 4'd0,
    ACT_VELOCITY  = 4'd1,
    ACT_BUZZ_ON   = 4'd2,
    ACT_BUZZ_OFF  = 4'd3,
    ACT_FWD_DIST  = 4'd4,
    ACT_BACK_DIST = 4'd5,
    ACT_ROT_R     = 4'd6,
    ACT_ROT_L     = 4'd7,
    ACT_SERVO1    = 4'd8,
    ACT_SERVO2    = 4'd9,
    ACT_SERVO3    = 4'd10,
    ACT_LCD       = 4'd11,
    ACT_BAR       = 4'd12,
    ACT_SENSOR    = 4'd13,
    ACT_ID        = 4'd14
  } action_t;

  typedef enum logic [3:0] {
    MODE_NONE   = 4'd0,
    MODE_VEL    = 4'd1,
    MODE_FWD    = 4'd2,
    MODE_BACK   = 4'd3,
    MODE_ROTR   = 4'd4,
    MODE_ROTL   = 4'd5,
    MODE_SERVO1 = 4'd6,
    MODE_SERVO2 = 4'd7,
    MODE_SERVO3 = 4'd8,
    MODE_LCD    = 4'd9,
    MODE_BAR    = 4'd10
  } mode_t;

  // Declared from the highest bits down so that action sits in the lowest bits.
  typedef struct packed {
    logic [7:0]  column_sel;
    logic [7:0]  row_sel;
    logic [7:0]  arg_byte;
    logic [15:0] amount;
    logic [7:0]  right_speed;
    logic [7:0]  left_speed;
    logic [3:0]  motion_dir;
    action_t     action;
  } result_t;

endpackage

`default_nettype wire

// ===== design/serial_robot_command_decoder.sv =====
// A result item is registered and appears on the output in the cycle after the byte that completes it.
// Throughput: one byte per cycle; a byte is taken whenever the output register is empty
// or is being emptied in the same cycle.
// Reset (rst_n low, synchronous): no command pending, output empty, device_id back to 5.
// Command decoder for a byte-oriented robot control protocol.
// Depends on srcd_pkg for the codes and the result item type.
`timescale 1ns / 1ps
`default_nettype none

module serial_robot_command_decoder
  import srcd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_data,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // rx_byte[7:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // action[3:0], motion_dir[7:4], left_speed[15:8], right_speed[23:16],
  // amount[39:24], arg_byte[47:40], row_sel[55:48], column_sel[63:56]
  output logic [63:0]      out_tdata
);

  logic [7:0] dev_id_r;
  mode_t      mode_r, mode_nxt;
  logic [1:0] arg_idx_r, arg_idx_nxt;
  logic [7:0] first_arg_r, first_arg_nxt;
  logic [7:0] second_arg_r, second_arg_nxt;
  result_t    out_r, out_nxt;
  logic       out_valid_r;
  logic       emit;
  logic       in_acc;
  logic [15:0] amount_calc;

  assign cfg_ready  = 1'b1;
  assign in_tready  = !out_valid_r || out_tready;
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r;

  // q*255 + r, computed as (q << 8) - q + r.
  assign amount_calc = {first_arg_r, 8'd0} - {8'd0, first_arg_r} + {8'd0, in_tdata};

  always_comb begin
    mode_nxt       = mode_r;
    arg_idx_nxt    = arg_idx_r;
    first_arg_nxt  = first_arg_r;
    second_arg_nxt = second_arg_r;
    out_nxt        = '0;
    emit           = 1'b0;
    case (mode_r)
      MODE_NONE: begin
        arg_idx_nxt = 2'd0;
        case (in_tdata)
          CMD_FWD: begin
            emit = 1'b1; out_nxt.action = ACT_MOTION; out_nxt.motion_dir = DIR_FWD;
          end
          CMD_BACK: begin
            emit = 1'b1; out_nxt.action = ACT_MOTION; out_nxt.motion_dir = DIR_BACK;
          end
          CMD_RIGHT: begin
            emit = 1'b1; out_nxt.action = ACT_MOTION; out_nxt.motion_dir = DIR_RIGHT;
          end
          CMD_LEFT: begin
            emit = 1'b1; out_nxt.action = ACT_MOTION; out_nxt.motion_dir = DIR_LEFT;
          end
          CMD_STOP: begin
            emit = 1'b1; out_nxt.action = ACT_MOTION; out_nxt.motion_dir = DIR_STOP;
          end
          CMD_BUZZ_ON: begin
            emit = 1'b1; out_nxt.action = ACT_BUZZ_ON;
          end
          CMD_BUZZ_OFF: begin
            emit = 1'b1; out_nxt.action = ACT_BUZZ_OFF;
          end
          CMD_FULL_SPD: begin
            emit = 1'b1; out_nxt.action = ACT_VELOCITY;
            out_nxt.left_speed = FULL_SPEED; out_nxt.right_speed = FULL_SPEED;
          end
          CMD_SENSOR: begin
            emit = 1'b1; out_nxt.action = ACT_SENSOR;
          end
          CMD_ID: begin
            emit = 1'b1; out_nxt.action = ACT_ID; out_nxt.arg_byte = dev_id_r;
          end
          CMD_VEL:       mode_nxt = MODE_VEL;
          CMD_FWD_DIST:  mode_nxt = MODE_FWD;
          CMD_BACK_DIST: mode_nxt = MODE_BACK;
          CMD_ROT_R:     mode_nxt = MODE_ROTR;
          CMD_ROT_L:     mode_nxt = MODE_ROTL;
          CMD_SERVO1:    mode_nxt = MODE_SERVO1;
          CMD_SERVO2:    mode_nxt = MODE_SERVO2;
          CMD_SERVO3:    mode_nxt = MODE_SERVO3;
          CMD_LCD:       mode_nxt = MODE_LCD;
          CMD_BAR:       mode_nxt = MODE_BAR;
          default: ;
        endcase
      end
      MODE_SERVO1, MODE_SERVO2, MODE_SERVO3, MODE_BAR: begin
        emit = 1'b1;
        out_nxt.arg_byte = in_tdata;
        mode_nxt = MODE_NONE;
        arg_idx_nxt = 2'd0;
        case (mode_r)
          MODE_SERVO1: out_nxt.action = ACT_SERVO1;
          MODE_SERVO2: out_nxt.action = ACT_SERVO2;
          MODE_SERVO3: out_nxt.action = ACT_SERVO3;
          default:     out_nxt.action = ACT_BAR;
        endcase
      end
      MODE_LCD: begin
        case (arg_idx_r)
          2'd0: begin
            first_arg_nxt = in_tdata; arg_idx_nxt = 2'd1;
          end
          2'd1: begin
            second_arg_nxt = in_tdata; arg_idx_nxt = 2'd2;
          end
          default: begin
            emit = 1'b1;
            out_nxt.action = ACT_LCD;
            out_nxt.arg_byte = in_tdata;
            out_nxt.row_sel = first_arg_r;
            out_nxt.column_sel = second_arg_r;
            mode_nxt = MODE_NONE;
            arg_idx_nxt = 2'd0;
          end
        endcase
      end
      MODE_VEL, MODE_FWD, MODE_BACK, MODE_ROTR, MODE_ROTL: begin
        if (arg_idx_r == 2'd0) begin
          first_arg_nxt = in_tdata;
          arg_idx_nxt = 2'd1;
        end else begin
          second_arg_nxt = in_tdata;
          emit = 1'b1;
          mode_nxt = MODE_NONE;
          arg_idx_nxt = 2'd0;
          case (mode_r)
            MODE_VEL: begin
              out_nxt.action = ACT_VELOCITY;
              out_nxt.left_speed = first_arg_r;
              out_nxt.right_speed = in_tdata;
            end
            MODE_FWD: begin
              out_nxt.action = ACT_FWD_DIST; out_nxt.amount = amount_calc;
            end
            MODE_BACK: begin
              out_nxt.action = ACT_BACK_DIST; out_nxt.amount = amount_calc;
            end
            MODE_ROTR: begin
              out_nxt.action = ACT_ROT_R; out_nxt.amount = amount_calc;
            end
            default: begin
              out_nxt.action = ACT_ROT_L; out_nxt.amount = amount_calc;
            end
          endcase
        end
      end
      default: begin
        mode_nxt = MODE_NONE;
        arg_idx_nxt = 2'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_id_r     <= DEVICE_ID_RESET;
      mode_r       <= MODE_NONE;
      arg_idx_r    <= 2'd0;
      first_arg_r  <= 8'd0;
      second_arg_r <= 8'd0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        dev_id_r <= cfg_data;
      end
      if (in_acc) begin
        mode_r       <= mode_nxt;
        arg_idx_r    <= arg_idx_nxt;
        first_arg_r  <= first_arg_nxt;
        second_arg_r <= second_arg_nxt;
      end
      if (in_acc) begin
        out_valid_r <= emit || (out_valid_r && !out_tready);
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && emit) begin
      out_r <= out_nxt;
    end
  end

  a_idx_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_NONE) |-> (arg_idx_r == 2'd0))
    else $error("argument index set with no command pending");

  a_idx_lcd: assert property (@(posedge clk) disable iff (!rst_n)
    (arg_idx_r == 2'd2) |-> (mode_r == MODE_LCD))
    else $error("third argument slot used outside the LCD command");

  a_id_reply: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && mode_r == MODE_NONE && in_tdata == CMD_ID)
      |=> (out_valid_r && out_r.action == ACT_ID && out_r.arg_byte == dev_id_r))
    else $error("identity query did not produce the identity reply");

  a_one_arg_done: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (mode_r == MODE_SERVO1 || mode_r == MODE_SERVO2 ||
                mode_r == MODE_SERVO3 || mode_r == MODE_BAR))
      |=> (mode_r == MODE_NONE && out_valid_r))
    else $error("single-argument command did not complete");

endmodule

`default_nettype wire

// ===== tb/sv/serial_robot_command_decoder_tb.sv =====
// Self-checking testbench for serial_robot_command_decoder.
// Drives received bytes and device_id writes, predicts every result item and
// compares it field by field. Depends on srcd_pkg and the decoder RTL.
`timescale 1ns / 1ps

module serial_robot_command_decoder_tb;
  import srcd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int IDLE_PCT = 17;
  localparam int PHASE_BYTES = 300;
  localparam int HOLD_CYCLES = 80;

  class decode_scoreboard;
    mode_t      mode;
    logic [1:0] arg_idx;
    logic [7:0] first_b;
    logic [7:0] second_b;
    logic [7:0] dev_id;
    result_t    expected_q[$];
    int         errors;
    int         results_checked;
    bit         seen_action[16];

    function new();
      mode = MODE_NONE;
      arg_idx = '0;
      first_b = '0;
      second_b = '0;
      dev_id = DEVICE_ID_RESET;
      errors = 0;
      results_checked = 0;
    endfunction

    function string show(result_t r);
      return $sformatf("action=%0d dir=%0d left=%0d right=%0d amount=%0d arg=%0h row=%0d col=%0d",
                       r.action, r.motion_dir, r.left_speed, r.right_speed, r.amount,
                       r.arg_byte, r.row_sel, r.column_sel);
    endfunction

    function void note_byte(logic [7:0] b);
      result_t r;
      bit      emit;
      r = '0;
      emit = 1'b0;
      case (mode)
        MODE_NONE: begin
          emit = 1'b1;
          case (b)
            CMD_FWD:      r.motion_dir = DIR_FWD;
            CMD_BACK:     r.motion_dir = DIR_BACK;
            CMD_RIGHT:    r.motion_dir = DIR_RIGHT;
            CMD_LEFT:     r.motion_dir = DIR_LEFT;
            CMD_STOP:     r.motion_dir = DIR_STOP;
            CMD_BUZZ_ON:  r.action = ACT_BUZZ_ON;
            CMD_BUZZ_OFF: r.action = ACT_BUZZ_OFF;
            CMD_FULL_SPD: begin
              r.action = ACT_VELOCITY;
              r.left_speed = FULL_SPEED;
              r.right_speed = FULL_SPEED;
            end
            CMD_SENSOR:   r.action = ACT_SENSOR;
            CMD_ID: begin
              r.action = ACT_ID;
              r.arg_byte = dev_id;
            end
            default: begin
              emit = 1'b0;
              arg_idx = '0;
              case (b)
                CMD_VEL:       mode = MODE_VEL;
                CMD_FWD_DIST:  mode = MODE_FWD;
                CMD_BACK_DIST: mode = MODE_BACK;
                CMD_ROT_R:     mode = MODE_ROTR;
                CMD_ROT_L:     mode = MODE_ROTL;
                CMD_SERVO1:    mode = MODE_SERVO1;
                CMD_SERVO2:    mode = MODE_SERVO2;
                CMD_SERVO3:    mode = MODE_SERVO3;
                CMD_LCD:       mode = MODE_LCD;
                CMD_BAR:       mode = MODE_BAR;
                default: ;
              endcase
            end
          endcase
        end
        MODE_SERVO1: begin
          r.action = ACT_SERVO1;
          r.arg_byte = b;
          emit = 1'b1;
        end
        MODE_SERVO2: begin
          r.action = ACT_SERVO2;
          r.arg_byte = b;
          emit = 1'b1;
        end
        MODE_SERVO3: begin
          r.action = ACT_SERVO3;
          r.arg_byte = b;
          emit = 1'b1;
        end
        MODE_BAR: begin
          r.action = ACT_BAR;
          r.arg_byte = b;
          emit = 1'b1;
        end
        MODE_LCD: begin
          if (arg_idx == 2'd0) begin
            first_b = b;
          end else if (arg_idx == 2'd1) begin
            second_b = b;
          end else begin
            r.action = ACT_LCD;
            r.row_sel = first_b;
            r.column_sel = second_b;
            r.arg_byte = b;
            emit = 1'b1;
          end
          arg_idx = arg_idx + 2'd1;
        end
        default: begin
          if (arg_idx == 2'd0) begin
            first_b = b;
            arg_idx = 2'd1;
          end else begin
            second_b = b;
            emit = 1'b1;
            case (mode)
              MODE_VEL: begin
                r.action = ACT_VELOCITY;
                r.left_speed = first_b;
                r.right_speed = b;
              end
              MODE_FWD:  r.action = ACT_FWD_DIST;
              MODE_BACK: r.action = ACT_BACK_DIST;
              MODE_ROTR: r.action = ACT_ROT_R;
              default:   r.action = ACT_ROT_L;
            endcase
            if (mode != MODE_VEL) r.amount = first_b * 16'd255 + b;
          end
        end
      endcase
      if (emit) begin
        mode = MODE_NONE;
        arg_idx = '0;
        expected_q.push_back(r);
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("Unexpected result item: %s", show(got));
        return;
      end
      want = expected_q.pop_front();
      results_checked++;
      seen_action[got.action] = 1'b1;
      if (got.action !== want.action || got.motion_dir !== want.motion_dir ||
          got.left_speed !== want.left_speed || got.right_speed !== want.right_speed ||
          got.amount !== want.amount || got.arg_byte !== want.arg_byte ||
          got.row_sel !== want.row_sel || got.column_sel !== want.column_sel) begin
        errors++;
        if (errors <= 10) begin
          $display("Mismatch on result %0d", results_checked);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // rx_byte[7:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // action[3:0], motion_dir[7:4], left_speed[15:8], right_speed[23:16],
  // amount[39:24], arg_byte[47:40], row_sel[55:48], column_sel[63:56]
  logic [63:0] out_tdata;

  decode_scoreboard sb = new();
  bit          quiet = 1'b0;
  bit          stall_req = 1'b0;
  int          bytes_sent = 0;
  int          id_writes = 0;
  int unsigned cycles = 0;

  logic [7:0] cmd_codes [20] = '{
    CMD_FWD, CMD_BACK, CMD_RIGHT, CMD_LEFT, CMD_STOP, CMD_BUZZ_ON, CMD_BUZZ_OFF,
    CMD_FULL_SPD, CMD_SENSOR, CMD_ID, CMD_VEL, CMD_FWD_DIST, CMD_BACK_DIST,
    CMD_ROT_R, CMD_ROT_L, CMD_SERVO1, CMD_SERVO2, CMD_SERVO3, CMD_LCD, CMD_BAR
  };

  // Every command once, unknown bytes at both extremes, argument extremes, and
  // command codes sent as arguments, which must be consumed as data.
  logic [7:0] directed_q[$] = '{
    CMD_FWD, CMD_BACK, CMD_RIGHT, CMD_LEFT, CMD_STOP, CMD_BUZZ_ON, CMD_BUZZ_OFF,
    CMD_FULL_SPD, CMD_SENSOR, CMD_ID, 8'h00, 8'hFF,
    CMD_VEL, 8'h00, 8'hFF,
    CMD_FWD_DIST, 8'hFF, 8'hFF,
    CMD_BACK_DIST, 8'h00, 8'h00,
    CMD_ROT_R, 8'h01, 8'hFE,
    CMD_ROT_L, 8'h80, 8'h7F,
    CMD_SERVO1, CMD_VEL,
    CMD_SERVO2, 8'hFF,
    CMD_SERVO3, 8'h00,
    CMD_LCD, CMD_LCD, 8'hFF, CMD_ID,
    CMD_BAR, 8'hAA
  };

  serial_robot_command_decoder u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycles, sb.expected_q.size());
      $display("FAIL serial_robot_command_decoder");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_result(result_t'(out_tdata));
      if (in_tvalid && in_tready) sb.note_byte(in_tdata);
    end
  end

  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (stall_req) begin
        hold = HOLD_CYCLES;
        stall_req = 1'b0;
      end
      if (hold > 0) begin
        hold--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= quiet || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  task automatic send_byte(logic [7:0] b);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
  endtask

  function automatic logic [7:0] pick_arg();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic send_command();
    logic [7:0] code;
    int         nargs;
    if ($urandom_range(99) < 12) begin
      send_byte(8'($urandom_range(255)));
      return;
    end
    code = cmd_codes[$urandom_range(19)];
    case (code)
      CMD_VEL, CMD_FWD_DIST, CMD_BACK_DIST, CMD_ROT_R, CMD_ROT_L: nargs = 2;
      CMD_SERVO1, CMD_SERVO2, CMD_SERVO3, CMD_BAR:                nargs = 1;
      CMD_LCD:                                                    nargs = 3;
      default:                                                    nargs = 0;
    endcase
    send_byte(code);
    repeat (nargs) send_byte(pick_arg());
  endtask

  task automatic write_device_id(logic [7:0] value);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.dev_id = value;
    id_writes++;
  endtask

  initial begin
    int         ph;
    int         phase_start;
    int         kinds;
    logic [7:0] value;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed_q[i]) send_byte(directed_q[i]);

    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: value = 8'h00;
        1: value = 8'hFF;
        5: value = DEVICE_ID_RESET;
        default: value = 8'($urandom_range(255));
      endcase
      write_device_id(value);
      quiet = (ph == 2);
      if (ph == 3) stall_req = 1'b1;
      send_byte(CMD_ID);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) send_command();
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);

    kinds = 0;
    foreach (sb.seen_action[k]) kinds += sb.seen_action[k];
    $display("Sent %0d bytes across %0d device_id settings; checked %0d results, %0d mismatches.",
             bytes_sent, id_writes + 1, sb.results_checked, sb.errors);
    $display("Saw %0d of 15 actions, with idle-free traffic and a long output hold-off.",
             kinds);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("PASS serial_robot_command_decoder");
    end else begin
      $display("FAIL serial_robot_command_decoder");
    end
    $finish;
  end

endmodule
